// ----- hw/rtl/gbts_pkg.sv -----
// ----------------------------------------------------------------------------
// gbts_pkg: shared constants for the gap-buffer text store
// Field widths, operation, origin and status codes, parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF    = 1024;
    localparam int MAX_READ_DEF = 64;

    // Field widths
    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int OFF_W    = 12;
    localparam int ORG_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE   = 3'd4;

    // Move origins
    localparam logic [ORG_W-1:0] ORG_START  = 2'd0;
    localparam logic [ORG_W-1:0] ORG_CURSOR = 2'd1;
    localparam logic [ORG_W-1:0] ORG_END    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/gap_buffer_text_store.sv -----
// Clear, insert, delete, unused codes and reads that return nothing give one result,
// passing through S_EXEC and S_EMIT into the output register.
// Move: S_MOVE reads and S_MWR writes the RAM for each byte shifted across the gap.
// Read: S_RD reads and S_RWR writes the RAM for each byte, one result per byte, up to
// MAX_READ results per request.
// Throughput: one request at a time; s_ready is high only while the sequencer is idle,
// and a stalled output holds the sequencer. The single RAM port pair sets the byte rate.
// Reset: empty text (gap spans the whole store); RAM contents are left as they are.
// ----------------------------------------------------------------------------
// gap_buffer_text_store: gap-buffer text store with byte-serial gap moves
// A small sequencer runs each request through one RAM read/write pair.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store #(
    parameter int DEPTH    = gbts_pkg::DEPTH_DEF,
    parameter int MAX_READ = gbts_pkg::MAX_READ_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Request channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [gbts_pkg::OP_W-1:0]     s_operation,
    input  wire logic        [gbts_pkg::CHAR_W-1:0]   s_data_char,
    input  wire logic        [gbts_pkg::COUNT_W-1:0]  s_count,
    input  wire logic signed [gbts_pkg::OFF_W-1:0]    s_offset,
    input  wire logic        [gbts_pkg::ORG_W-1:0]    s_origin,
    // Result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [gbts_pkg::STATUS_W-1:0] m_status,
    output logic             [gbts_pkg::CHAR_W-1:0]   m_read_char,
    output logic             [gbts_pkg::COUNT_W-1:0]  m_amount,
    output logic             [gbts_pkg::POS_W-1:0]    m_cursor,
    output logic             [gbts_pkg::POS_W-1:0]    m_text_size,
    output logic                                      m_last
);

    import gbts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int WW = (AW > COUNT_W) ? AW : COUNT_W;
    localparam int TW = ((AW > OFF_W) ? AW : OFF_W) + 2;
    localparam int RW = $clog2(MAX_READ + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_MOVE = 7'b0000100,
        S_MWR  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_RWR  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]        gs_reg, gs_next;
    logic [AW-1:0]        ge_reg, ge_next;
    logic [OP_W-1:0]      op_reg;
    logic [CHAR_W-1:0]    ch_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [ORG_W-1:0]     org_reg;
    logic [AW-1:0]        tgt_reg, tgt_next;
    logic [RW-1:0]        want_reg, want_next;
    logic [RW-1:0]        got_reg, got_next;
    logic                 left_reg, left_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [COUNT_W-1:0]   res_amount_reg, res_amount_next;

    // Output register
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg, out_status;
    logic [CHAR_W-1:0]    m_read_char_reg, out_char;
    logic [COUNT_W-1:0]   m_amount_reg, out_amount;
    logic [POS_W-1:0]     m_cursor_reg;
    logic [POS_W-1:0]     m_text_size_reg;
    logic                 m_last_reg, out_last;
    logic                 out_load;
    logic                 out_free;

    // RAM port
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [CHAR_W-1:0]    ram_wdata, ram_rdata;

    // Datapath helpers
    logic [AW-1:0]        size_cur, size_nxt, avail;
    logic [WW-1:0]        cnt_x, avail_x, del_x, cur_x, sz_x;
    logic [RW-1:0]        got_inc;
    logic [AW-1:0]        base;
    logic signed [TW-1:0] base_s, off_s, t_s, size_s;
    logic [AW-1:0]        tgt_calc;

    gbts_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Size and delete span from the gap pointers
    assign size_cur = AW'(LAST_IDX - ge_reg + gs_reg);
    assign size_nxt = AW'(LAST_IDX - ge_next + gs_next);
    assign avail    = AW'(LAST_IDX - ge_reg);
    assign cnt_x    = WW'(cnt_reg);
    assign avail_x  = WW'(avail);
    assign del_x    = (cnt_x < avail_x) ? cnt_x : avail_x;
    assign got_inc  = RW'(got_reg + 1'b1);
    assign cur_x    = WW'(gs_next);
    assign sz_x     = WW'(size_nxt);

    // Move target: base plus offset, clamped to 0..size
    always_comb begin
        case (org_reg)
            ORG_START:  base = '0;
            ORG_CURSOR: base = gs_reg;
            default:    base = size_cur;
        endcase
        base_s = TW'(base);
        off_s  = TW'(off_reg);
        size_s = TW'(size_cur);
        t_s    = base_s + off_s;
        if (t_s < 0) begin
            tgt_calc = '0;
        end else if (t_s > size_s) begin
            tgt_calc = size_cur;
        end else begin
            tgt_calc = AW'(t_s);
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        gs_next         = gs_reg;
        ge_next         = ge_reg;
        tgt_next        = tgt_reg;
        want_next       = want_reg;
        got_next        = got_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_amount_next = res_amount_reg;
        ram_we          = 1'b0;
        ram_waddr       = gs_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = AW'(ge_reg + 1'b1);
        out_load        = 1'b0;
        out_status      = res_status_reg;
        out_char        = '0;
        out_amount      = res_amount_reg;
        out_last        = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_status_next = ST_OK;
                res_amount_next = '0;
                state_next      = S_EMIT;
                case (op_reg)
                    OP_CLEAR: begin
                        gs_next = '0;
                        ge_next = LAST_IDX;
                    end
                    OP_INSERT: begin
                        if (size_cur == LAST_IDX) begin
                            res_status_next = ST_FULL;
                        end else begin
                            ram_we          = 1'b1;
                            ram_waddr       = gs_reg;
                            ram_wdata       = ch_reg;
                            gs_next         = AW'(gs_reg + 1'b1);
                            res_amount_next = COUNT_W'(1);
                        end
                    end
                    OP_DELETE: begin
                        if (cnt_reg != '0 && avail == '0) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            ge_next         = AW'(ge_reg + AW'(del_x));
                            res_amount_next = del_x[COUNT_W-1:0];
                        end
                    end
                    OP_READ: begin
                        want_next = (cnt_reg < COUNT_W'(MAX_READ)) ? RW'(cnt_reg)
                                                                    : RW'(MAX_READ);
                        got_next  = '0;
                        if (cnt_reg == '0) begin
                            state_next = S_EMIT;
                        end else if (ge_reg == LAST_IDX) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                    OP_MOVE: begin
                        if (org_reg == ORG_START || org_reg == ORG_CURSOR ||
                            org_reg == ORG_END) begin
                            tgt_next   = tgt_calc;
                            state_next = S_MOVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Pick the shift direction and fetch the byte that crosses the gap
            S_MOVE: begin
                if (gs_reg > tgt_reg && gs_reg != '0) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(gs_reg - 1'b1);
                    left_next  = 1'b1;
                    state_next = S_MWR;
                end else if (gs_reg < tgt_reg && ge_reg != LAST_IDX) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(ge_reg + 1'b1);
                    left_next  = 1'b0;
                    state_next = S_MWR;
                end else begin
                    state_next = S_EMIT;
                end
            end

            // Store the byte on the far side of the gap
            S_MWR: begin
                ram_we = 1'b1;
                if (left_reg) begin
                    ram_waddr = ge_reg;
                    gs_next   = AW'(gs_reg - 1'b1);
                    ge_next   = AW'(ge_reg - 1'b1);
                end else begin
                    ram_waddr = gs_reg;
                    gs_next   = AW'(gs_reg + 1'b1);
                    ge_next   = AW'(ge_reg + 1'b1);
                end
                state_next = S_MOVE;
            end

            S_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(ge_reg + 1'b1);
                state_next = S_RWR;
            end

            // Move the read byte before the cursor and emit it
            S_RWR: begin
                if (out_free) begin
                    ram_we     = 1'b1;
                    ram_waddr  = gs_reg;
                    gs_next    = AW'(gs_reg + 1'b1);
                    ge_next    = AW'(ge_reg + 1'b1);
                    got_next   = got_inc;
                    out_load   = 1'b1;
                    out_status = ST_OK;
                    out_char   = ram_rdata;
                    out_amount = COUNT_W'(got_inc);
                    out_last   = (got_inc == want_reg) ||
                                 (AW'(ge_reg + 1'b1) == LAST_IDX);
                    state_next = out_last ? S_IDLE : S_RD;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            gs_reg      <= '0;
            ge_reg      <= LAST_IDX;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            gs_reg    <= gs_next;
            ge_reg    <= ge_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and working registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            ch_reg  <= s_data_char;
            cnt_reg <= s_count;
            off_reg <= s_offset;
            org_reg <= s_origin;
        end
        tgt_reg        <= tgt_next;
        want_reg       <= want_next;
        got_reg        <= got_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_amount_reg <= res_amount_next;
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg    <= out_status;
            m_read_char_reg <= out_char;
            m_amount_reg    <= out_amount;
            m_cursor_reg    <= cur_x[POS_W-1:0];
            m_text_size_reg <= sz_x[POS_W-1:0];
            m_last_reg      <= out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_read_char = m_read_char_reg;
    assign m_amount    = m_amount_reg;
    assign m_cursor    = m_cursor_reg;
    assign m_text_size = m_text_size_reg;
    assign m_last      = m_last_reg;

    // The gap always keeps at least one free cell
    a_gap_open: assert property (@(posedge aclk) disable iff (!aresetn)
        gs_reg <= ge_reg)
        else $error("gap pointers crossed");

    // A request is taken only when the sequencer is idle, never twice in a row
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // A result is only loaded while the output slot is free
    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwrote a pending result");

    // A left shift never starts with the cursor at the start of text
    a_left_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MWR && left_reg) |-> (gs_reg != '0))
        else $error("left shift at start of text");

endmodule

`default_nettype wire

// ----- hw/rtl/gbts_ram.sv -----
// ----------------------------------------------------------------------------
// gbts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- test/gap_buffer_text_store_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test: self-checking bench for the gap-buffer text store
// Drives clear, insert, delete, read and move requests over the request channel.
// A tracker keeps its own copy of the text and gap, predicts every result and
// checks each one in order. Idling and stalls vary by phase, and one long
// receiver hold-off keeps the result slot full and stalls the sequencer.
// ----------------------------------------------------------------------------

module gap_buffer_text_store_test;

    import gbts_pkg::*;

    localparam int TEXT_DEPTH  = DEPTH_DEF;
    localparam int READ_CAP    = MAX_READ_DEF;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 64;
    localparam int FILL_ITEMS  = 40;
    localparam int TAIL_CYCLES = 20;

    // Codes outside the defined sets
    localparam logic [ORG_W-1:0] ORG_NONE       = 2'd3;
    localparam logic [OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]  OP_SPARE_MID   = 3'd6;
    localparam logic [OP_W-1:0]  OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   read_char;
        logic [COUNT_W-1:0]  amount;
        logic [POS_W-1:0]    cursor;
        logic [POS_W-1:0]    text_size;
        logic                last;
    } text_result_t;

    // Tracks the text around its gap and holds the results still due
    class gap_text_tracker;
        logic [CHAR_W-1:0] text_mem [TEXT_DEPTH];
        int                gap_lo;
        int                gap_hi;
        text_result_t      due_results [$];
        int                errors;

        function new();
            foreach (text_mem[i]) text_mem[i] = '0;
            gap_lo = 0;
            gap_hi = TEXT_DEPTH - 1;
            errors = 0;
        endfunction

        function int text_len();
            return TEXT_DEPTH - (gap_hi + 1 - gap_lo);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void add_result(logic [STATUS_W-1:0] st, logic [CHAR_W-1:0] ch, int amt,
                                 logic fin);
            text_result_t r;
            r.status    = st;
            r.read_char = ch;
            r.amount    = COUNT_W'(amt);
            r.cursor    = POS_W'(gap_lo);
            r.text_size = POS_W'(text_len());
            r.last      = fin;
            due_results.push_back(r);
        endfunction

        // Apply one accepted request and queue the results it causes
        function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [COUNT_W-1:0] cnt, logic signed [OFF_W-1:0] off,
                                   logic [ORG_W-1:0] org);
            int avail;
            int span;
            int want;
            int got;
            int base;
            int target;
            logic [CHAR_W-1:0] byte_out;
            case (op)
                OP_CLEAR: begin
                    gap_lo = 0;
                    gap_hi = TEXT_DEPTH - 1;
                    add_result(ST_OK, '0, 0, 1'b1);
                end
                OP_INSERT: begin
                    if (text_len() >= TEXT_DEPTH - 1) begin
                        add_result(ST_FULL, '0, 0, 1'b1);
                    end else begin
                        text_mem[gap_lo] = ch;
                        gap_lo++;
                        add_result(ST_OK, '0, 1, 1'b1);
                    end
                end
                OP_DELETE: begin
                    avail = TEXT_DEPTH - 1 - gap_hi;
                    span  = (int'(cnt) < avail) ? int'(cnt) : avail;
                    if (cnt != 0 && avail == 0) begin
                        add_result(ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        gap_hi += span;
                        add_result(ST_OK, '0, span, 1'b1);
                    end
                end
                OP_READ: begin
                    want = (int'(cnt) < READ_CAP) ? int'(cnt) : READ_CAP;
                    got  = 0;
                    if (want == 0) begin
                        add_result(ST_OK, '0, 0, 1'b1);
                    end else if (gap_hi + 1 >= TEXT_DEPTH) begin
                        add_result(ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        // Emit each byte and step the cursor past it
                        while (got < want && gap_hi + 1 < TEXT_DEPTH) begin
                            byte_out         = text_mem[gap_hi + 1];
                            text_mem[gap_lo] = byte_out;
                            gap_lo++;
                            gap_hi++;
                            got++;
                            add_result(ST_OK, byte_out, got,
                                       (got == want) || (gap_hi + 1 >= TEXT_DEPTH));
                        end
                    end
                end
                OP_MOVE: begin
                    if (org != ORG_NONE) begin
                        base = (org == ORG_START) ? 0 :
                               (org == ORG_CURSOR) ? gap_lo : text_len();
                        target = base + int'(off);
                        if (target < 0) target = 0;
                        if (target > text_len()) target = text_len();
                        // Shift bytes across the gap until the cursor lands
                        while (gap_lo > target) begin
                            gap_lo--;
                            text_mem[gap_hi] = text_mem[gap_lo];
                            gap_hi--;
                        end
                        while (gap_lo < target) begin
                            text_mem[gap_lo] = text_mem[gap_hi + 1];
                            gap_lo++;
                            gap_hi++;
                        end
                    end
                    add_result(ST_OK, '0, 0, 1'b1);
                end
                default: begin
                    add_result(ST_OK, '0, 0, 1'b1);
                end
            endcase
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        // Match one accepted result against the oldest one due
        function void check_result(text_result_t got);
            text_result_t want;
            if (due_results.size() == 0) begin
                $error("result with no request outstanding: status %0d amount %0d",
                       got.status, got.amount);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare("status", int'(want.status), int'(got.status));
            compare("read_char", int'(want.read_char), int'(got.read_char));
            compare("amount", int'(want.amount), int'(got.amount));
            compare("cursor", int'(want.cursor), int'(got.cursor));
            compare("text_size", int'(want.text_size), int'(got.text_size));
            compare("last", int'(want.last), int'(got.last));
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic        [OP_W-1:0]     s_operation;
    logic        [CHAR_W-1:0]   s_data_char;
    logic        [COUNT_W-1:0]  s_count;
    logic signed [OFF_W-1:0]    s_offset;
    logic        [ORG_W-1:0]    s_origin;
    logic                       m_valid;
    logic                       m_ready;
    logic        [STATUS_W-1:0] m_status;
    logic        [CHAR_W-1:0]   m_read_char;
    logic        [COUNT_W-1:0]  m_amount;
    logic        [POS_W-1:0]    m_cursor;
    logic        [POS_W-1:0]    m_text_size;
    logic                       m_last;

    gap_text_tracker tracker;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              requests_sent  = 0;
    int              cycle_count    = 0;
    int              hold_left      = 0;
    bit              hold_start     = 1'b0;

    gap_buffer_text_store u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_data_char (s_data_char),
        .s_count     (s_count),
        .s_offset    (s_offset),
        .s_origin    (s_origin),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_char (m_read_char),
        .m_amount    (m_amount),
        .m_cursor    (m_cursor),
        .m_text_size (m_text_size),
        .m_last      (m_last)
    );

    always #10 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one request, idling first at the current rate, and hold it until taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [COUNT_W-1:0] cnt,
                                input logic signed [OFF_W-1:0] off,
                                input logic [ORG_W-1:0] org);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data_char <= ch;
        s_count     <= cnt;
        s_offset    <= off;
        s_origin    <= org;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(op, ch, cnt, off, org);
        requests_sent++;
    endtask

    // Send one request of the given code with random side fields
    task automatic send_noise(input logic [OP_W-1:0] op);
        send_request(op, CHAR_W'($urandom), COUNT_W'($urandom), OFF_W'($urandom),
                     ORG_W'($urandom));
    endtask

    // Pick one random request, or a whole load sequence
    task automatic send_random();
        logic [OP_W-1:0]     op;
        logic [CHAR_W-1:0]   ch;
        logic [COUNT_W-1:0]  cnt;
        logic signed [OFF_W-1:0] off;
        logic [ORG_W-1:0]    org;
        int                  pick;
        int                  load_len;
        ch  = CHAR_W'($urandom);
        cnt = COUNT_W'($urandom);
        off = OFF_W'($urandom);
        org = ORG_W'($urandom);
        if ($urandom_range(0, 9) != 0) cnt = COUNT_W'($urandom_range(0, 24));
        if ($urandom_range(0, 7) != 0) off = OFF_W'(int'($urandom_range(0, 80)) - 40);
        if (org == ORG_NONE && $urandom_range(0, 7) != 0) org = ORG_W'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        // Keep the text short so gap moves stay cheap
        if (tracker.text_len() > 240 && pick >= 7 && pick < 40) pick = 45;
        if (pick < 4) begin
            load_len = $urandom_range(1, 24);
            send_noise(OP_CLEAR);
            repeat (load_len) send_noise(OP_INSERT);
            send_request(OP_MOVE, CHAR_W'($urandom), COUNT_W'($urandom), '0, ORG_START);
        end else begin
            if (pick < 7)       op = OP_CLEAR;
            else if (pick < 40) op = OP_INSERT;
            else if (pick < 52) op = OP_DELETE;
            else if (pick < 68) op = OP_READ;
            else if (pick < 97) op = OP_MOVE;
            else                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_request(op, ch, cnt, off, org);
        end
    endtask

    // Receive results: check on each handshake, then set the next ready
    initial begin : result_side
        text_result_t seen;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                seen.status    = m_status;
                seen.read_char = m_read_char;
                seen.amount    = m_amount;
                seen.cursor    = m_cursor;
                seen.text_size = m_text_size;
                seen.last      = m_last;
                tracker.check_result(seen);
            end
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : request_side
        int i;
        int phase;
        int target;
        tracker     = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_CLEAR;
        s_data_char = '0;
        s_count     = '0;
        s_offset    = '0;
        s_origin    = ORG_START;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty text, edge bytes, clamps, spare codes
        send_request(OP_READ, 8'h00, 11'd5, 12'sd0, ORG_START);
        send_request(OP_DELETE, 8'hFF, 11'd3, 12'sd0, ORG_START);
        send_request(OP_READ, 8'h00, 11'd0, 12'sd0, ORG_START);
        send_request(OP_DELETE, 8'h00, 11'd0, 12'sd0, ORG_START);
        send_request(OP_INSERT, 8'h00, 11'd0, 12'sd0, ORG_START);
        send_request(OP_INSERT, 8'hFF, 11'd2047, -12'sd1, ORG_NONE);
        send_request(OP_INSERT, 8'hA5, 11'd0, 12'sd0, ORG_START);
        send_request(OP_INSERT, 8'h5A, 11'd0, 12'sd0, ORG_START);
        send_request(OP_INSERT, 8'h3C, 11'd0, 12'sd0, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd0, ORG_START);
        send_request(OP_READ, 8'h00, 11'd2, 12'sd0, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, -12'sd1, ORG_CURSOR);
        send_request(OP_MOVE, 8'h00, 11'd0, -12'sd1024, ORG_END);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd1024, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd1, ORG_CURSOR);
        send_request(OP_MOVE, 8'h00, 11'd0, -12'sd2, ORG_NONE);
        send_request(OP_MOVE, 8'h00, 11'd0, -12'sd2, ORG_END);
        send_request(OP_DELETE, 8'h00, 11'd1024, 12'sd0, ORG_START);
        send_request(OP_SPARE_FIRST, 8'hFF, 11'd2047, 12'sd2047, ORG_NONE);
        send_request(OP_SPARE_MID, 8'h81, 11'd1, -12'sd2048, ORG_END);
        send_request(OP_SPARE_LAST, 8'h7E, 11'd1023, 12'sd1023, ORG_CURSOR);
        send_request(OP_MOVE, 8'h00, 11'd0, -12'sd2048, ORG_CURSOR);
        send_request(OP_READ, 8'h00, 11'd2047, 12'sd0, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd2047, ORG_START);
        send_request(OP_CLEAR, 8'hFF, 11'd2047, -12'sd1, ORG_NONE);

        // Fill part way, then sweep the whole text
        for (i = 0; i < FILL_ITEMS; i++) begin
            send_noise(OP_INSERT);
        end
        send_request(OP_INSERT, 8'hFF, 11'd0, 12'sd0, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd0, ORG_START);
        send_request(OP_READ, 8'h00, 11'd1024, 12'sd0, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd1024, ORG_END);
        send_request(OP_INSERT, 8'h11, 11'd0, 12'sd0, ORG_START);
        send_request(OP_MOVE, 8'h00, 11'd0, 12'sd511, ORG_START);
        send_request(OP_READ, 8'h00, 11'd64, 12'sd0, ORG_START);
        send_request(OP_DELETE, 8'h00, 11'd2047, 12'sd0, ORG_START);
        send_request(OP_INSERT, 8'h22, 11'd0, 12'sd0, ORG_START);
        send_request(OP_CLEAR, 8'h00, 11'd0, 12'sd0, ORG_START);

        // Random phases with different idle and stall rates
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_start     = 1'b1;
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target) send_random();
        end

        // Drain and report
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
